### rtl/assert_macros.svh
// Assertion macros shared by the RTL files that carry checks.
// No dependencies; pulled in with an include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// General clocked property, disabled while reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// Condition in one cycle implies a condition in the next, disabled in reset
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

### rtl/trsc_pkg.sv
// Shared types, codes and constants of the register/stack machine execute block.
// No dependencies.
package trsc_pkg;

	localparam int STACK_DEPTH_DEF = 128;
	localparam int REG_COUNT       = 8;
	localparam int REG_IDX_W       = $clog2(REG_COUNT);

	localparam logic [REG_IDX_W-1:0] SP_INDEX = REG_IDX_W'(7);
	localparam logic [7:0]           SP_RESET = 8'd128;

	typedef logic [REG_COUNT-1:0][7:0] regfile_t;

	// Opcodes
	typedef enum logic [7:0] {
		OP_GREET     = 8'd1,
		OP_HALT      = 8'd2,
		OP_PRINT_IMM = 8'd3,
		OP_PRINT_SUM = 8'd4,
		OP_LOAD_IMM  = 8'd5,
		OP_PRINT_REG = 8'd6,
		OP_ADD       = 8'd7,
		OP_PUSH      = 8'd8,
		OP_POP       = 8'd9
	} opcode_t;

	// Result status codes
	typedef enum logic [2:0] {
		ST_NONE    = 3'd0,
		ST_PRINT   = 3'd1,
		ST_GREET   = 3'd2,
		ST_HALT    = 3'd3,
		ST_ILLEGAL = 3'd4,
		ST_HALTED  = 3'd5
	} status_t;

	// State updates produced by one executed instruction
	typedef struct packed {
		logic                 halt_set;
		logic                 reg_we;
		logic [REG_IDX_W-1:0] reg_idx;
		logic [7:0]           reg_data;
		logic                 sp_we;
		logic [7:0]           sp_data;
		logic                 stk_we;
		logic [7:0]           stk_data;
		logic [7:0]           next_addr;
		status_t              status;
		logic [8:0]           value;
	} upd_t;

	localparam regfile_t REGS_RESET = {SP_RESET, {(REG_COUNT-1){8'd0}}};

endpackage

### rtl/trsc_exec.sv
// Instruction decode and execute logic: turns one instruction plus current
// machine state into a set of state updates and a result. Uses trsc_pkg.
module trsc_exec (
	input  logic              halted,
	input  logic [7:0]        cur_addr,
	input  trsc_pkg::regfile_t regs,
	input  logic [7:0]        command,
	input  logic [7:0]        operand_a,
	input  logic [7:0]        operand_b,
	input  logic [7:0]        stack_rd,
	output trsc_pkg::upd_t    upd
);
	import trsc_pkg::*;

	logic [REG_IDX_W-1:0] ia;
	logic [REG_IDX_W-1:0] ib;
	logic [7:0]           sp;
	logic [7:0]           sp_dec;
	logic [1:0]           len;

	assign ia     = operand_a[REG_IDX_W-1:0];
	assign ib     = operand_b[REG_IDX_W-1:0];
	assign sp     = regs[SP_INDEX];
	assign sp_dec = sp - 8'd1;

	// Decode and execute
	always_comb begin
		upd          = '0;
		upd.status   = ST_NONE;
		len          = 2'd0;
		if (halted) begin
			upd.status = ST_HALTED;
		end else begin
			case (command)
				OP_GREET: begin
					upd.status = ST_GREET;
					len        = 2'd1;
				end
				OP_HALT: begin
					upd.status   = ST_HALT;
					upd.halt_set = 1'b1;
					len          = 2'd1;
				end
				OP_PRINT_IMM: begin
					upd.status = ST_PRINT;
					upd.value  = {1'b0, operand_a};
					len        = 2'd2;
				end
				OP_PRINT_SUM: begin
					upd.status = ST_PRINT;
					upd.value  = {1'b0, operand_a} + {1'b0, operand_b};
					len        = 2'd3;
				end
				OP_LOAD_IMM: begin
					upd.reg_we   = 1'b1;
					upd.reg_idx  = ib;
					upd.reg_data = operand_a;
					len          = 2'd3;
				end
				OP_PRINT_REG: begin
					upd.status = ST_PRINT;
					upd.value  = {1'b0, regs[ia]};
					len        = 2'd2;
				end
				OP_ADD: begin
					upd.reg_we   = 1'b1;
					upd.reg_idx  = ia;
					upd.reg_data = regs[ia] + regs[ib];
					len          = 2'd3;
				end
				OP_PUSH: begin
					// SP drops first; pushing SP stores the dropped value
					upd.sp_we    = 1'b1;
					upd.sp_data  = sp_dec;
					upd.stk_we   = 1'b1;
					upd.stk_data = (ia == SP_INDEX) ? sp_dec : regs[ia];
					len          = 2'd2;
				end
				OP_POP: begin
					// register written first, then SP bumped (pop into SP: value + 1)
					upd.reg_we   = 1'b1;
					upd.reg_idx  = ia;
					upd.reg_data = stack_rd;
					upd.sp_we    = 1'b1;
					upd.sp_data  = ((ia == SP_INDEX) ? stack_rd : sp) + 8'd1;
					len          = 2'd2;
				end
				default: begin
					upd.status   = ST_ILLEGAL;
					upd.halt_set = 1'b1;
				end
			endcase
		end
		upd.next_addr = cur_addr + {6'd0, len};
	end

endmodule

### rtl/toy_register_stack_cpu_execute.sv
// Channel  | Dir | Fields (low bit up)                         | Request when
// s_*      | in  | command[7:0] operand_a[15:8] operand_b[23:16] | s_tvalid & s_tready
// m_*      | out | status[2:0] print_value[11:3] next_address[19:12] | m_tvalid & m_tready
//
// One instruction per cycle sustained while the output is not stalled; a request passes
// through the input register, then the result register, before its result is valid.
// The stack read is issued as the instruction enters its input register, using
// the SP left by the instruction executing in that cycle, with write bypass.
// Reset clears registers (SP = 128), address and halt flag; the stack memory is
// not cleared. A stalled output holds the result and backs up the input side.
//
// Top level of the register/stack machine execute block.
// Depends on trsc_pkg, trsc_exec and assert_macros.svh.
`include "assert_macros.svh"

module toy_register_stack_cpu_execute #(
	parameter int STACK_DEPTH = trsc_pkg::STACK_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // command, operand_a, operand_b
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata    // status, print_value, next_address, zero pad
);
	import trsc_pkg::*;

	localparam int AW = $clog2(STACK_DEPTH);

	// Input stage
	logic       s1_valid_q;
	logic [7:0] cmd_s1;
	logic [7:0] opa_s1;
	logic [7:0] opb_s1;
	logic [7:0] rdata_s1;
	logic       fwd_s1;
	logic [7:0] fwd_data_s1;

	// Machine state
	regfile_t   regs_q;
	regfile_t   regs_d;
	logic [7:0] iaddr_q;
	logic       halted_q;

	// Result register
	logic       m_valid_q;
	status_t    status_q;
	logic [8:0] value_q;
	logic [7:0] naddr_q;

	logic       s_fire;
	logic       exec;
	logic       out_free;
	upd_t       upd;
	logic [7:0] stack_rd;
	logic [AW-1:0] raddr;
	logic [AW-1:0] waddr;
	logic [7:0]    stack_mem [STACK_DEPTH];
	logic [AW-1:0] mod_tbl [256];

	// SP to stack index, reduced modulo the depth
	for (genvar i = 0; i < 256; i++) begin : g_mod
		assign mod_tbl[i] = AW'(i % STACK_DEPTH);
	end

	// Handshake
	assign out_free = !m_valid_q || m_tready;
	assign exec     = s1_valid_q && out_free;
	assign s_tready = !s1_valid_q || exec;
	assign s_fire   = s_tvalid && s_tready;

	assign stack_rd = fwd_s1 ? fwd_data_s1 : rdata_s1;

	trsc_exec u_exec (
		.halted    (halted_q),
		.cur_addr  (iaddr_q),
		.regs      (regs_q),
		.command   (cmd_s1),
		.operand_a (opa_s1),
		.operand_b (opb_s1),
		.stack_rd  (stack_rd),
		.upd       (upd)
	);

	// Register file after this cycle's instruction
	always_comb begin
		regs_d = regs_q;
		if (exec) begin
			if (upd.reg_we) begin
				regs_d[upd.reg_idx] = upd.reg_data;
			end
			if (upd.sp_we) begin
				regs_d[SP_INDEX] = upd.sp_data;
			end
		end
	end

	assign raddr = mod_tbl[regs_d[SP_INDEX]];
	assign waddr = mod_tbl[upd.sp_data];

	// Stack memory: write from the executing push, read for the entering item
	always_ff @(posedge clk) begin
		if (exec && upd.stk_we) begin
			stack_mem[waddr] <= upd.stk_data;
		end
		if (s_fire) begin
			rdata_s1    <= stack_mem[raddr];
			fwd_s1      <= exec && upd.stk_we && (waddr == raddr);
			fwd_data_s1 <= upd.stk_data;
		end
	end

	// Input register payload
	always_ff @(posedge clk) begin
		if (s_fire) begin
			cmd_s1 <= s_tdata[7:0];
			opa_s1 <= s_tdata[15:8];
			opb_s1 <= s_tdata[23:16];
		end
	end

	// Input valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_tready) begin
			s1_valid_q <= s_tvalid;
		end
	end

	// Machine state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q   <= REGS_RESET;
			iaddr_q  <= 8'd0;
			halted_q <= 1'b0;
		end else if (exec) begin
			regs_q   <= regs_d;
			iaddr_q  <= upd.next_addr;
			halted_q <= halted_q || upd.halt_set;
		end
	end

	// Result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_free) begin
			m_valid_q <= s1_valid_q;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (exec) begin
			status_q <= upd.status;
			value_q  <= upd.value;
			naddr_q  <= upd.next_addr;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {4'd0, naddr_q, value_q, status_q};

	// Checks
	`ASSERT_NEXT(a_halt_sticky, clk, arst_n, halted_q, halted_q, "halt flag cleared")
	`ASSERT_NEXT(a_halted_result, clk, arst_n, exec && halted_q,
		status_q == ST_HALTED && naddr_q == $past(iaddr_q), "halted item not ignored")
	`ASSERT_NEXT(a_push_sp, clk, arst_n, exec && !halted_q && cmd_s1 == OP_PUSH,
		regs_q[SP_INDEX] == 8'($past(regs_q[SP_INDEX]) - 8'd1), "push did not drop SP")
	`ASSERT_CLK(a_value_zero, clk, arst_n,
		m_valid_q && status_q != ST_PRINT |-> value_q == 9'd0, "value set without print")

endmodule

### test/toy_register_stack_cpu_execute_tb.sv
// Testbench for the register/stack machine execute block: drives instruction
// requests, mirrors the machine state in a shadow class and checks each result.
// Depends on trsc_pkg and the toy_register_stack_cpu_execute top level.
`timescale 1ns / 100ps

module toy_register_stack_cpu_execute_tb;
	import trsc_pkg::*;

	localparam int STACK_DEPTH  = STACK_DEPTH_DEF;
	localparam int RANDOM_ITEMS = 1050;
	localparam int HALTED_ITEMS = 20;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 10;
	localparam int CYCLE_LIMIT  = 200000;

	typedef struct packed {
		status_t    status;
		logic [8:0] print_value;
		logic [7:0] next_address;
	} exec_result_t;

	// Shadow copy of the machine and the queue of results it has predicted
	class cpu_shadow;
		logic [7:0]   regs [REG_COUNT];
		logic [7:0]   stack_mem [STACK_DEPTH];
		bit           stack_written [STACK_DEPTH];
		logic [7:0]   pc;
		bit           stopped;
		exec_result_t pending_results [$];
		int           errors;

		function new();
			foreach (regs[i]) regs[i] = 8'd0;
			regs[SP_INDEX] = SP_RESET;
			foreach (stack_written[i]) stack_written[i] = 1'b0;
			pc = 8'd0;
			stopped = 1'b0;
			errors = 0;
		endfunction

		function int slot_of(logic [7:0] sp);
			return int'(sp) % STACK_DEPTH;
		endfunction

		// A pop is only legal when the slot under SP holds pushed data
		function bit pop_ok();
			return stack_written[slot_of(regs[SP_INDEX])];
		endfunction

		// Execute one accepted instruction and queue the result it must give
		function void note_instruction(logic [7:0] cmd, logic [7:0] a, logic [7:0] b);
			exec_result_t r;
			logic [2:0]   ra;
			logic [2:0]   rb;
			logic [7:0]   len;
			r.status = ST_NONE;
			r.print_value = 9'd0;
			len = 8'd0;
			ra = a[2:0];
			rb = b[2:0];
			if (stopped) begin
				r.status = ST_HALTED;
			end else begin
				case (cmd)
					OP_GREET: begin
						r.status = ST_GREET;
						len = 8'd1;
					end
					OP_HALT: begin
						r.status = ST_HALT;
						stopped = 1'b1;
						len = 8'd1;
					end
					OP_PRINT_IMM: begin
						r.status = ST_PRINT;
						r.print_value = {1'b0, a};
						len = 8'd2;
					end
					OP_PRINT_SUM: begin
						r.status = ST_PRINT;
						r.print_value = {1'b0, a} + {1'b0, b};
						len = 8'd3;
					end
					OP_LOAD_IMM: begin
						regs[rb] = a;
						len = 8'd3;
					end
					OP_PRINT_REG: begin
						r.status = ST_PRINT;
						r.print_value = {1'b0, regs[ra]};
						len = 8'd2;
					end
					OP_ADD: begin
						regs[ra] = regs[ra] + regs[rb];
						len = 8'd3;
					end
					OP_PUSH: begin
						// SP moves first, so pushing SP stores the new value
						regs[SP_INDEX] = regs[SP_INDEX] - 8'd1;
						stack_mem[slot_of(regs[SP_INDEX])] = regs[ra];
						stack_written[slot_of(regs[SP_INDEX])] = 1'b1;
						len = 8'd2;
					end
					OP_POP: begin
						// destination first, then SP; popping into SP gives value + 1
						regs[ra] = stack_mem[slot_of(regs[SP_INDEX])];
						regs[SP_INDEX] = regs[SP_INDEX] + 8'd1;
						len = 8'd2;
					end
					default: begin
						r.status = ST_ILLEGAL;
						stopped = 1'b1;
					end
				endcase
				pc = pc + len;
			end
			r.next_address = pc;
			pending_results.push_back(r);
		endfunction

		// Compare one accepted result with the oldest prediction
		function void check_result(logic [23:0] data);
			exec_result_t want;
			if (pending_results.size() == 0) begin
				$display("%0t: result with nothing expected: %h", $time, data);
				errors++;
				return;
			end
			want = pending_results.pop_front();
			if (data[2:0] !== want.status) begin
				$display("%0t: status expected %0d actual %0d", $time, want.status, data[2:0]);
				errors++;
			end
			if (data[11:3] !== want.print_value) begin
				$display("%0t: print_value expected %0d actual %0d", $time,
					want.print_value, data[11:3]);
				errors++;
			end
			if (data[19:12] !== want.next_address) begin
				$display("%0t: next_address expected %0d actual %0d", $time,
					want.next_address, data[19:12]);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;   // command, operand_a, operand_b
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;   // status, print_value, next_address, zero pad

	cpu_shadow shadow = new();
	int        send_idle_pct;
	int        recv_idle_pct;
	bit        hold_req;
	int        cycles;

	toy_register_stack_cpu_execute #(
		.STACK_DEPTH(STACK_DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Run limit
	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("toy_register_stack_cpu_execute_tb: FAIL");
		$finish;
	end

	// Result side: check accepted results, then pick tready for the next edge
	initial begin
		int hold_left;
		bit hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready)
				shadow.check_result(m_tdata);
			if (hold_req && !hold_done) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= arst_n && ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Offer one instruction request, hold it until taken, then predict it
	task automatic issue(input logic [7:0] cmd, input logic [7:0] a, input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {b, a, cmd};
		do @(posedge clk); while (!s_tready);
		shadow.note_instruction(cmd, a, b);
	endtask

	// Random legal instruction; pops only land on slots that were pushed
	task automatic issue_random();
		logic [7:0] cmd;
		int         roll;
		roll = $urandom_range(99);
		if (roll < 20)
			cmd = OP_PUSH;
		else if (roll < 42)
			cmd = shadow.pop_ok() ? OP_POP : OP_PUSH;
		else if (roll < 54)
			cmd = OP_LOAD_IMM;
		else if (roll < 66)
			cmd = OP_ADD;
		else if (roll < 76)
			cmd = OP_PRINT_REG;
		else if (roll < 84)
			cmd = OP_PRINT_IMM;
		else if (roll < 94)
			cmd = OP_PRINT_SUM;
		else
			cmd = OP_GREET;
		issue(cmd, 8'($urandom_range(255)), 8'($urandom_range(255)));
	endtask

	// Main sequence
	initial begin
		logic [7:0] bad_cmd;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = 24'd0;
		hold_req = 1'b0;
		send_idle_pct = 31;
		recv_idle_pct = 49;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: field extremes, index masking, wrap, stack corner cases
		issue(OP_GREET, 8'h00, 8'h00);
		issue(OP_PRINT_IMM, 8'h00, 8'hFF);
		issue(OP_PRINT_IMM, 8'hFF, 8'h00);
		issue(OP_PRINT_SUM, 8'hFF, 8'hFF);
		issue(OP_PRINT_SUM, 8'h00, 8'h00);
		issue(OP_PRINT_REG, 8'hFF, 8'h00);
		issue(OP_LOAD_IMM, 8'hFF, 8'h08);
		issue(OP_LOAD_IMM, 8'h80, 8'hF9);
		issue(OP_ADD, 8'h10, 8'h01);
		issue(OP_PRINT_REG, 8'h00, 8'h00);
		issue(OP_PUSH, 8'h00, 8'h00);
		issue(OP_PUSH, 8'h07, 8'h00);
		issue(OP_PRINT_REG, 8'h07, 8'h00);
		issue(OP_POP, 8'h02, 8'h00);
		issue(OP_POP, 8'hFF, 8'h00);
		issue(OP_PRINT_REG, 8'h02, 8'h00);
		issue(OP_PRINT_REG, 8'h07, 8'h00);
		issue(OP_LOAD_IMM, 8'h00, 8'h07);
		issue(OP_PUSH, 8'h03, 8'h00);
		issue(OP_POP, 8'hFC, 8'h00);
		issue(OP_PRINT_REG, 8'h04, 8'h00);
		issue(OP_PRINT_REG, 8'h07, 8'h00);

		// Random legal program in three idle profiles, long output stall in the last
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS / 3) begin
				send_idle_pct = 49;
				recv_idle_pct = 31;
			end else if (i == 2 * RANDOM_ITEMS / 3) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
				hold_req = 1'b1;
			end
			issue_random();
		end

		// Stop the machine by halt or by an unknown opcode, then check it stays stopped
		if ($urandom_range(1) == 1) begin
			issue(OP_HALT, 8'($urandom_range(255)), 8'($urandom_range(255)));
		end else begin
			do bad_cmd = 8'($urandom_range(255));
			while (bad_cmd >= OP_GREET && bad_cmd <= OP_POP);
			issue(bad_cmd, 8'($urandom_range(255)), 8'($urandom_range(255)));
		end
		for (int i = 0; i < HALTED_ITEMS; i++)
			issue(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)));
		s_tvalid <= 1'b0;

		while (shadow.pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (shadow.errors == 0)
			$display("toy_register_stack_cpu_execute_tb: PASS");
		else
			$display("toy_register_stack_cpu_execute_tb: FAIL");
		$finish;
	end

endmodule
